@@ src/tidr_pkg.sv @@
// Shared constants and types for the touch input debounce reporter.
package tidr_pkg;

    // Debounce window setup.
    localparam logic [3:0]  WINDOW_SAMPLES  = 4'd10;
    localparam logic [3:0]  MATCH_THRESHOLD = 4'd4;
    localparam logic [2:0]  SAMPLE_GAP      = 3'd3;

    // Report timing.
    localparam logic [15:0] OFFLINE_PERIOD  = 16'd100;
    localparam logic [15:0] PERIOD_MIN      = 16'd10;
    localparam logic [15:0] PERIOD_RESET    = 16'd100;
    localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

    // Report mode codes.
    localparam logic [1:0]  MODE_PERIODIC   = 2'd0;
    localparam logic [1:0]  MODE_CHANGE     = 2'd1;
    localparam logic [1:0]  MODE_NONE       = 2'd2;

    // Configuration register indexes.
    localparam int          CFG_IDX_W       = 4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_MODE   = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 4'd1;

    // One tick as held in the input register.
    typedef struct packed {
        logic [3:0] pins;
        logic       online;
        logic       read_req;
    } t_tick;

    // Report flags raised for one tick.
    typedef struct packed {
        logic host;
        logic block;
    } t_report;

endpackage

@@ src/touch_input_debounce_reporter_top.sv @@
// Top level of the touch input debounce reporter: tick pipeline, config and result register.
//
// Each input transfer is one millisecond tick. The block takes one tick per clock cycle while
// o_stall is low and returns exactly one result per tick: the tick is held in the input
// register, then the debounce and report logic updates all state as the result is written
// into the output register. With the output stalled, the input register still takes one
// more tick before o_stall rises. The touch pins are sampled every fourth tick and a sample
// window is ten samples, so the debounced value can change at most once per forty ticks.
// Configuration writes are always ready and should be issued only while no tick is in
// flight; report_period writes below 10 are clamped to 10, and writes to unknown indexes
// are dropped.
module touch_input_debounce_reporter_top
    import tidr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Tick input channel.
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [3:0]           i_touch_pins,
    input  logic                 i_online,
    input  logic                 i_read_request,
    // Result channel.
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [3:0]           o_debounced_value,
    output logic                 o_host_report,
    output logic                 o_block_report,
    output logic                 o_read_reply,
    // Configuration write channel.
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    logic [1:0]  r_report_mode;
    logic [15:0] r_report_period;

    logic        r_in_valid;
    t_tick       r_in;

    logic        r_out_valid;
    logic [3:0]  r_out_value;
    t_report     r_out_report;
    logic        r_out_reply;

    logic        out_ready;
    logic        in_ready;
    logic        advance;
    logic [3:0]  stable_next;
    t_report     report;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report_mode   <= MODE_PERIODIC;
            r_report_period <= PERIOD_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IDX_MODE: begin
                    r_report_mode <= i_cfg_data[1:0];
                end
                CFG_IDX_PERIOD: begin
                    r_report_period <= (i_cfg_data < PERIOD_MIN) ? PERIOD_MIN : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // The result register frees up when empty or when its transfer completes.
    assign out_ready = !r_out_valid || !i_stall;
    assign in_ready  = !r_in_valid || out_ready;
    assign advance   = r_in_valid && out_ready;
    assign o_stall   = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in.pins     <= i_touch_pins;
            r_in.online   <= i_online;
            r_in.read_req <= i_read_request;
        end
    end

    tidr_debounce u_debounce (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (advance),
        .i_pins        (r_in.pins),
        .o_stable_next (stable_next)
    );

    tidr_report u_report (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_online (r_in.online),
        .i_mode   (r_report_mode),
        .i_period (r_report_period),
        .i_stable (stable_next),
        .o_report (report)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_value  <= stable_next;
            r_out_report <= report;
            r_out_reply  <= r_in.read_req;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_debounced_value = r_out_value;
    assign o_host_report     = r_out_report.host;
    assign o_block_report    = r_out_report.block;
    assign o_read_reply      = r_out_reply;

    // Host and block reports depend on opposite online states.
    a_report_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_host_report && o_block_report))
        else $error("host and block report raised together");

    // The clamp keeps the period at or above its minimum.
    a_period_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_report_period >= PERIOD_MIN)
        else $error("report period below minimum");

    // Stall toward the source only when both stages hold a tick.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled with free pipeline space");

    // A tick in the input register reaches the output in the next cycle when not blocked.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> o_valid)
        else $error("advanced tick did not reach the result register");

endmodule

@@ src/tidr_debounce.sv @@
// Window threshold debouncer for the four touch pins (more than four of ten samples must match).
module tidr_debounce
    import tidr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic [3:0] i_pins,
    output logic [3:0] o_stable_next
);

    logic [2:0] r_gap,    n_gap;
    logic [3:0] r_wcount, n_wcount;
    logic [3:0] r_match,  n_match;
    logic [3:0] r_ref,    n_ref;
    logic [3:0] r_stable, n_stable;

    logic [3:0] wcount_inc;
    logic [3:0] match_inc;

    always_comb begin
        n_gap      = r_gap;
        n_wcount   = r_wcount;
        n_match    = r_match;
        n_ref      = r_ref;
        n_stable   = r_stable;
        wcount_inc = r_wcount + 4'd1;
        match_inc  = r_match;
        if (r_gap < SAMPLE_GAP) begin
            n_gap = r_gap + 3'd1;
        end else begin
            n_gap = 3'd0;
            // The first sample of a window becomes its reference.
            if (r_wcount == 4'd0) begin
                n_ref = i_pins;
            end
            if (i_pins == n_ref) begin
                match_inc = r_match + 4'd1;
            end
            if (wcount_inc >= WINDOW_SAMPLES) begin
                n_wcount = 4'd0;
                n_match  = 4'd0;
                if (match_inc > MATCH_THRESHOLD) begin
                    n_stable = n_ref;
                end
            end else begin
                n_wcount = wcount_inc;
                n_match  = match_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap    <= 3'd0;
            r_wcount <= 4'd0;
            r_match  <= 4'd0;
            r_ref    <= 4'd0;
            r_stable <= 4'd0;
        end else if (i_en) begin
            r_gap    <= n_gap;
            r_wcount <= n_wcount;
            r_match  <= n_match;
            r_ref    <= n_ref;
            r_stable <= n_stable;
        end
    end

    assign o_stable_next = n_stable;

endmodule

@@ src/tidr_report.sv @@
// Host and block report scheduling with saturating elapsed counters.
module tidr_report
    import tidr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_online,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_period,
    input  logic [3:0]  i_stable,
    output t_report     o_report
);

    logic [15:0] r_host_elapsed,  n_host_elapsed;
    logic [15:0] r_block_elapsed, n_block_elapsed;
    logic [3:0]  r_last,          n_last;
    t_report     report;

    always_comb begin
        n_host_elapsed  = (r_host_elapsed == ELAPSED_MAX) ? ELAPSED_MAX
                                                          : r_host_elapsed + 16'd1;
        n_block_elapsed = (r_block_elapsed == ELAPSED_MAX) ? ELAPSED_MAX
                                                           : r_block_elapsed + 16'd1;
        n_last          = r_last;
        report          = '0;
        if (i_online) begin
            case (i_mode)
                MODE_PERIODIC: begin
                    if (n_host_elapsed > i_period) begin
                        n_host_elapsed = 16'd0;
                        report.host    = 1'b1;
                    end
                end
                MODE_CHANGE: begin
                    if (i_stable != r_last) begin
                        n_last      = i_stable;
                        report.host = 1'b1;
                    end
                end
                default: begin
                    // No automatic report.
                end
            endcase
        end else begin
            if (n_block_elapsed > OFFLINE_PERIOD) begin
                n_block_elapsed = 16'd0;
                report.block    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_host_elapsed  <= 16'd0;
            r_block_elapsed <= 16'd0;
            r_last          <= 4'd0;
        end else if (i_en) begin
            r_host_elapsed  <= n_host_elapsed;
            r_block_elapsed <= n_block_elapsed;
            r_last          <= n_last;
        end
    end

    assign o_report = report;

endmodule
